// ===== hdl/pscg_pkg.sv =====
// Shared types, constants and small lookup functions for phrase_synced_cc_glide.
// No dependencies; imported by pscg_msg_buf and phrase_synced_cc_glide.
package pscg_pkg;

	localparam int NUM_CTRL_DEF  = 4;
	localparam int LVL_FRAC_DEF  = 16;
	localparam int TIME_BITS_DEF = 48;

	localparam int T_W   = 47;
	localparam int D_W   = 18;
	localparam int TGT_W = 16;
	localparam int NN_W  = 38;
	localparam int NN_SCALE = 15360;

	localparam int MSG_DEPTH_DEF = NUM_CTRL_DEF + 2;

	localparam logic [2:0] REG_SAMPLE_RATE = 3'd0;
	localparam logic [2:0] REG_LEN_SEL     = 3'd1;
	localparam logic [2:0] REG_FIRST_CC    = 3'd2;
	localparam logic [2:0] REG_GLIDE_CH    = 3'd3;
	localparam logic [2:0] REG_POS_CC      = 3'd4;
	localparam logic [2:0] REG_POS_CH      = 3'd5;
	localparam logic [2:0] REG_LEN_CC      = 3'd6;
	localparam logic [2:0] REG_LEN_CH      = 3'd7;

	localparam logic [17:0] RST_SAMPLE_RATE = 18'd48000;
	localparam logic [2:0]  RST_LEN_SEL     = 3'd2;
	localparam logic [6:0]  RST_FIRST_CC    = 7'd1;
	localparam logic [4:0]  RST_GLIDE_CH    = 5'd1;
	localparam logic [6:0]  RST_POS_CC      = 7'd0;
	localparam logic [4:0]  RST_POS_CH      = 5'd16;
	localparam logic [6:0]  RST_LEN_CC      = 7'd0;
	localparam logic [4:0]  RST_LEN_CH      = 5'd16;

	typedef struct packed {
		logic [4:0] ch;
		logic [6:0] cc;
		logic [6:0] val;
	} msg_t;

	typedef struct packed {
		logic wr;
		logic clr;
		logic go;
	} buf_ctl_t;

	// log2 of the phrase length in beats
	function automatic logic [2:0] beats_shift(input logic [2:0] sel);
		logic [2:0] s;
		case (sel)
			3'd0: s = 3'd0;
			3'd1: s = 3'd2;
			3'd2: s = 3'd3;
			3'd3: s = 3'd4;
			3'd4: s = 3'd5;
			3'd5: s = 3'd6;
			default: s = 3'd2;
		endcase
		return s;
	endfunction

	// floor(sel*127/7)
	function automatic logic [6:0] len_value(input logic [2:0] sel);
		logic [6:0] v;
		case (sel)
			3'd0: v = 7'd0;
			3'd1: v = 7'd18;
			3'd2: v = 7'd36;
			3'd3: v = 7'd54;
			3'd4: v = 7'd72;
			3'd5: v = 7'd90;
			3'd6: v = 7'd108;
			default: v = 7'd127;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/pscg_msg_buf.sv =====
// Message buffer for one tick: collects controller messages, then streams them
// out over a valid/ready channel with a last flag. Depends on pscg_pkg.
module pscg_msg_buf #(
	parameter int DEPTH = pscg_pkg::MSG_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pscg_pkg::buf_ctl_t ctl,
	input  pscg_pkg::msg_t    wr_msg,
	output logic              busy,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [4:0]        msg_channel,
	output logic [6:0]        msg_controller,
	output logic [6:0]        msg_value,
	output logic              msg_last
);
	import pscg_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	msg_t          mem_q [DEPTH];
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] rd_q;
	logic          send_q;
	msg_t          rd_msg;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[cnt_q[AW-1:0]] <= wr_msg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			rd_q   <= '0;
			send_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				cnt_q <= '0;
			end else if (ctl.wr) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (ctl.go) begin
				send_q <= (cnt_q != '0);
				rd_q   <= '0;
			end else if (send_q && out_ready) begin
				if (msg_last) begin
					send_q <= 1'b0;
				end else begin
					rd_q <= rd_q + AW'(1);
				end
			end
		end
	end

	assign rd_msg         = mem_q[rd_q];
	assign msg_channel    = rd_msg.ch;
	assign msg_controller = rd_msg.cc;
	assign msg_value      = rd_msg.val;
	assign msg_last       = (CW'(rd_q) == (cnt_q - CW'(1)));
	assign out_valid      = send_q;
	assign busy           = send_q;

endmodule

// ===== hdl/phrase_synced_cc_glide.sv =====
// Top level of phrase_synced_cc_glide: bit-serial phrase arithmetic and glide update.
// Depends on pscg_pkg and pscg_msg_buf.
//
// Usage: one transfer on the input channel (in_valid/in_ready) carries a tick:
// play flag, playhead, tempo and the target levels. The block answers with
// zero to NUM_CONTROLLERS+2 controller messages on the output channel
// (out_valid/out_ready); msg_last marks the final message of the tick.
// Configuration is a plain write port (cfg_we, cfg_addr, cfg_wdata); the user must
// write it only while no tick is in flight, which the block itself does not enforce.
// Sequence: playhead mod phrase, the modular tempo product, the position quotient,
// the reports, then the glide increment (skipped when the glide is capped; its
// final division is skipped when the tempo product caps), each controller in turn
// and the start of the output. The messages are then delivered in order; a
// stalled receiver holds the current message. One tick is in work at a time; the
// bit-serial restoring dividers and shift-add multipliers set this.
// in_ready is low from acceptance until the message buffer has finished sending
// the last message and the state machine has returned to idle. Reset clears
// levels, sent values, previous playhead and configuration to their defaults.
module phrase_synced_cc_glide #(
	parameter int NUM_CONTROLLERS = pscg_pkg::NUM_CTRL_DEF,
	parameter int LEVEL_FRAC_BITS = pscg_pkg::LVL_FRAC_DEF,
	parameter int TIME_BITS       = pscg_pkg::TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        is_playing,
	input  logic [46:0] playhead_samples,
	input  logic [17:0] tempo_bpm_q8,
	input  logic [15:0] target_a,
	input  logic [15:0] target_b,
	input  logic [15:0] target_c,
	input  logic [15:0] target_d,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  msg_channel,
	output logic [6:0]  msg_controller,
	output logic [6:0]  msg_value,
	output logic        msg_last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [17:0] cfg_wdata
);
	import pscg_pkg::*;

	localparam int LV_W = LEVEL_FRAC_BITS + 1;
	localparam int CI_W = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;
	localparam int DW   = (TIME_BITS > NN_W) ? TIME_BITS : NN_W;
	localparam int ND_W = NN_W + D_W;
	localparam int PN_W = NN_W + 8;
	localparam int SH_UP = (LEVEL_FRAC_BITS >= TGT_W) ? LEVEL_FRAC_BITS - TGT_W : 0;
	localparam int SH_DN = (LEVEL_FRAC_BITS < TGT_W) ? TGT_W - LEVEL_FRAC_BITS : 0;
	localparam int VS_W = LEVEL_FRAC_BITS + 9;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MODT = 4'd1;
	localparam logic [3:0] ST_MULM = 4'd2;
	localparam logic [3:0] ST_PREP = 4'd3;
	localparam logic [3:0] ST_POS  = 4'd4;
	localparam logic [3:0] ST_HDRP = 4'd5;
	localparam logic [3:0] ST_HDRL = 4'd6;
	localparam logic [3:0] ST_NDM  = 4'd7;
	localparam logic [3:0] ST_NDC  = 4'd8;
	localparam logic [3:0] ST_FRAC = 4'd9;
	localparam logic [3:0] ST_CTL  = 4'd10;
	localparam logic [3:0] ST_GO   = 4'd11;
	localparam logic [3:0] ST_SEND = 4'd12;

	// configuration
	logic [17:0] sr_q;
	logic [2:0]  sel_q;
	logic [6:0]  first_q;
	logic [4:0]  gch_q;
	logic [6:0]  posn_q;
	logic [4:0]  posch_q;
	logic [6:0]  lenn_q;
	logic [4:0]  lench_q;

	logic [3:0]           state_q;
	logic [5:0]           cnt_q;
	logic                 ph_q;
	logic [T_W-1:0]       t_q;
	logic [D_W-1:0]       d_q;
	logic                 play_q;
	logic [TGT_W-1:0]     tg_q [4];
	logic [NN_W-1:0]      nn_q;
	logic [NN_W-1:0]      rem_q;
	logic [NN_W-1:0]      x_q;
	logic [NN_W-1:0]      acc_q;
	logic [PN_W-1:0]      pnum_q;
	logic [PN_W-1:0]      ds_q;
	logic [6:0]           pq_q;
	logic [NN_W-1:0]      den_q;
	logic [TIME_BITS-1:0] dlt_q;
	logic                 bw_q;
	logic                 cap_q;
	logic [ND_W-1:0]      nd_q;
	logic [NN_W-1:0]      fr_q;
	logic [31:0]          inc_q;
	logic [CI_W-1:0]      ci_q;
	logic [LV_W-1:0]      gl_q [NUM_CONTROLLERS];
	logic [6:0]           sv_q [NUM_CONTROLLERS];
	logic [TIME_BITS-1:0] prev_q;
	logic [LV_W+31:0]     prod_s1;
	logic                 up_s1;
	logic [LV_W-1:0]      tl_s1;
	logic [LV_W-1:0]      lv_s1;

	logic            in_xfer;
	logic            d_bit;
	logic [17:0]     rate_e;
	logic [31:0]     rmul;
	logic [NN_W-1:0] nn_calc;
	logic [NN_W:0]   mt_r2, mt_sub;
	logic [NN_W-1:0] mt_nx;
	logic [NN_W:0]   mm_a, mm_sub;
	logic [NN_W-1:0] mm_nx;
	logic [PN_W-1:0] pnum_calc;
	logic [PN_W-1:0] pn_sub;
	logic            pn_ge;
	logic [TIME_BITS-1:0] tm;
	logic [NN_W-1:0] dlt_lo;
	logic [ND_W-1:0] nd_nx;
	logic [NN_W:0]   fr2, fr_sub;
	logic            fr_ge;
	logic [39:0]     tw;
	logic [LV_W-1:0] tl, lv, diff;
	logic            up;
	logic [LV_W+32:0] rsum;
	logic [LV_W-1:0] step, nl;
	logic [VS_W-1:0] vs;
	logic [8:0]      v9;
	logic [6:0]      val;
	buf_ctl_t        bctl;
	msg_t            wmsg;
	logic            busy;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign d_bit    = d_q[cnt_q[4:0]];

	assign rate_e  = (sr_q == '0) ? 18'd1 : sr_q;
	assign rmul    = 32'(rate_e) * 32'(NN_SCALE);
	assign nn_calc = NN_W'({6'd0, rmul} << beats_shift(sel_q));

	assign mt_r2  = {rem_q, t_q[cnt_q]};
	assign mt_sub = mt_r2 - {1'b0, nn_q};
	assign mt_nx  = (mt_r2 >= {1'b0, nn_q}) ? mt_sub[NN_W-1:0] : mt_r2[NN_W-1:0];

	assign mm_a   = ph_q ? ({1'b0, acc_q} + (d_bit ? {1'b0, x_q} : '0)) : {acc_q, 1'b0};
	assign mm_sub = mm_a - {1'b0, nn_q};
	assign mm_nx  = (mm_a >= {1'b0, nn_q}) ? mm_sub[NN_W-1:0] : mm_a[NN_W-1:0];

	assign pnum_calc = PN_W'(acc_q) * PN_W'(254) + PN_W'(nn_q);
	assign pn_ge     = (pnum_q >= ds_q);
	assign pn_sub    = pnum_q - ds_q;

	assign tm     = TIME_BITS'({17'd0, t_q});
	assign dlt_lo = NN_W'(DW'(dlt_q));
	assign nd_nx  = {nd_q[ND_W-2:0], 1'b0} + (d_bit ? ND_W'(dlt_lo) : '0);

	assign fr2    = {fr_q, 1'b0};
	assign fr_ge  = (fr2 >= {1'b0, den_q});
	assign fr_sub = fr2 - {1'b0, den_q};

	// glide datapath
	assign tw   = ({24'd0, tg_q[2'(ci_q)]} << SH_UP) >> SH_DN;
	assign tl   = LV_W'(tw);
	assign lv   = gl_q[ci_q];
	assign up   = (tl >= lv);
	assign diff = up ? (tl - lv) : (lv - tl);
	assign rsum = (LV_W+33)'(prod_s1) + (LV_W+33)'(33'h080000000);
	assign step = rsum[32 +: LV_W];
	assign nl   = cap_q ? tl_s1 : (up_s1 ? (lv_s1 + step) : (lv_s1 - step));
	assign vs   = VS_W'(nl) * VS_W'(127) + (VS_W'(1) << (LEVEL_FRAC_BITS - 1));
	assign v9   = vs[LEVEL_FRAC_BITS +: 9];
	assign val  = (v9 > 9'd127) ? 7'd127 : v9[6:0];

	always_comb begin
		bctl.clr = in_xfer;
		bctl.go  = (state_q == ST_GO);
		bctl.wr  = 1'b0;
		wmsg.ch  = gch_q;
		wmsg.cc  = 7'(first_q + 7'(ci_q));
		wmsg.val = val;
		unique case (state_q)
			ST_HDRP: begin
				bctl.wr  = play_q && (posn_q != '0);
				wmsg.ch  = posch_q;
				wmsg.cc  = posn_q;
				wmsg.val = pq_q;
			end
			ST_HDRL: begin
				bctl.wr  = play_q && (lenn_q != '0);
				wmsg.ch  = lench_q;
				wmsg.cc  = lenn_q;
				wmsg.val = len_value(sel_q);
			end
			ST_CTL: begin
				bctl.wr = ph_q && (val != sv_q[ci_q]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_q    <= RST_SAMPLE_RATE;
			sel_q   <= RST_LEN_SEL;
			first_q <= RST_FIRST_CC;
			gch_q   <= RST_GLIDE_CH;
			posn_q  <= RST_POS_CC;
			posch_q <= RST_POS_CH;
			lenn_q  <= RST_LEN_CC;
			lench_q <= RST_LEN_CH;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SAMPLE_RATE: sr_q    <= cfg_wdata;
				REG_LEN_SEL:     sel_q   <= cfg_wdata[2:0];
				REG_FIRST_CC:    first_q <= cfg_wdata[6:0];
				REG_GLIDE_CH:    gch_q   <= cfg_wdata[4:0];
				REG_POS_CC:      posn_q  <= cfg_wdata[6:0];
				REG_POS_CH:      posch_q <= cfg_wdata[4:0];
				REG_LEN_CC:      lenn_q  <= cfg_wdata[6:0];
				REG_LEN_CH:      lench_q <= cfg_wdata[4:0];
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			t_q    <= playhead_samples;
			d_q    <= (tempo_bpm_q8 == '0) ? 18'd1 : tempo_bpm_q8;
			play_q <= is_playing;
			tg_q[0] <= target_a;
			tg_q[1] <= target_b;
			tg_q[2] <= target_c;
			tg_q[3] <= target_d;
			nn_q   <= nn_calc;
		end
		if (state_q == ST_MODT && cnt_q == '0) begin
			x_q <= mt_nx;
		end
		if (state_q == ST_PREP) begin
			pnum_q <= pnum_calc;
			ds_q   <= PN_W'(nn_q) << 7;
			den_q  <= nn_q - acc_q;
			dlt_q  <= tm - prev_q;
			bw_q   <= (tm < prev_q);
		end
		if (state_q == ST_POS) begin
			pq_q   <= {pq_q[5:0], pn_ge};
			pnum_q <= pn_ge ? pn_sub : pnum_q;
			ds_q   <= ds_q >> 1;
		end
		if (state_q == ST_CTL && !ph_q) begin
			prod_s1 <= (LV_W+32)'(diff) * (LV_W+32)'(inc_q);
			up_s1   <= up;
			tl_s1   <= tl;
			lv_s1   <= lv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ph_q    <= 1'b0;
			rem_q   <= '0;
			acc_q   <= '0;
			cap_q   <= 1'b0;
			nd_q    <= '0;
			fr_q    <= '0;
			inc_q   <= '0;
			ci_q    <= '0;
			prev_q  <= '0;
			for (int i = 0; i < NUM_CONTROLLERS; i++) begin
				gl_q[i] <= '0;
				sv_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						rem_q   <= '0;
						cnt_q   <= 6'(T_W - 1);
						state_q <= ST_MODT;
					end
				end
				ST_MODT: begin
					rem_q <= mt_nx;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						acc_q   <= '0;
						ph_q    <= 1'b0;
						cnt_q   <= 6'(D_W - 1);
						state_q <= ST_MULM;
					end
				end
				ST_MULM: begin
					acc_q <= mm_nx;
					ph_q  <= !ph_q;
					if (ph_q) begin
						cnt_q <= cnt_q - 6'd1;
						if (cnt_q == '0) begin
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					cnt_q   <= 6'd6;
					state_q <= ST_POS;
				end
				ST_POS: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						state_q <= ST_HDRP;
					end
				end
				ST_HDRP: begin
					cap_q   <= !play_q || bw_q || (DW'(dlt_q) >= DW'(den_q));
					state_q <= ST_HDRL;
				end
				ST_HDRL: begin
					ci_q <= '0;
					ph_q <= 1'b0;
					nd_q <= '0;
					cnt_q <= 6'(D_W - 1);
					state_q <= cap_q ? ST_CTL : ST_NDM;
				end
				ST_NDM: begin
					nd_q  <= nd_nx;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						state_q <= ST_NDC;
					end
				end
				ST_NDC: begin
					cap_q <= (nd_q >= ND_W'(den_q));
					fr_q  <= nd_q[NN_W-1:0];
					inc_q <= '0;
					cnt_q <= 6'd31;
					state_q <= (nd_q >= ND_W'(den_q)) ? ST_CTL : ST_FRAC;
				end
				ST_FRAC: begin
					fr_q  <= fr_ge ? fr_sub[NN_W-1:0] : fr2[NN_W-1:0];
					inc_q <= {inc_q[30:0], fr_ge};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						state_q <= ST_CTL;
					end
				end
				ST_CTL: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						gl_q[ci_q] <= nl;
						sv_q[ci_q] <= val;
						ci_q <= ci_q + CI_W'(1);
						if (ci_q == CI_W'(NUM_CONTROLLERS - 1)) begin
							state_q <= ST_GO;
						end
					end
				end
				ST_GO: begin
					prev_q  <= tm;
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (!busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	pscg_msg_buf #(
		.DEPTH(NUM_CONTROLLERS + 2)
	) u_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (bctl),
		.wr_msg        (wmsg),
		.busy          (busy),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.msg_channel   (msg_channel),
		.msg_controller(msg_controller),
		.msg_value     (msg_value),
		.msg_last      (msg_last)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while messages pending");
	a_modt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MODT) |-> (rem_q < nn_q))
		else $error("phrase remainder out of range");
	a_pos_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POS) |-> ({1'b0, pnum_q} < {ds_q, 1'b0}))
		else $error("position quotient overflow");
	a_frac_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FRAC) |-> (fr_q < den_q))
		else $error("increment remainder out of range");

endmodule
